FILE: rtl/bpc_pkg.sv
// shared types and constants for the pressure compensation block
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic               divide_fault;
  } out_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SIGNED_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_UNSIGNED_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SIGNED_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SIGNED_M   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLING   = 3'd4;

  localparam logic [1:0]  OSS_RESET   = 2'd3;
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] P_COEF_A    = 32'd3038;
  localparam logic [31:0] P_COEF_B    = 32'd7357;
  localparam logic [31:0] P_COEF_C    = 32'd3791;
  localparam logic signed [31:0] T_MAX = 32'sd32767;
  localparam logic signed [31:0] T_MIN = -32'sd32768;
  localparam logic signed [31:0] P_MAX = 32'sd1048575;

endpackage

FILE: rtl/barometric_pressure_compensation_top.sv
// top level of the barometric pressure and temperature compensation pipeline
// throughput: one sample per cycle, busy is always low; the two 32-stage dividers
// (temperature term and final pressure quotient) set most of the latency
// reset: synchronous active-low rst_n clears all valid bits, calibration to zero, oss to 3
// results cannot be held off by the receiver, so the pipeline never stalls
module barometric_pressure_compensation_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  bpc_pkg::in_t                       in_data,
  output logic                               out_valid,
  output bpc_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SIDE_A_W = 53;
  localparam int SIDE_B_W = 18;

  bpc_pkg::cal_t cal;

  // sign-extended / zero-extended coefficients
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  always_comb begin
    ac1 = {{16{cal.ac1[15]}}, cal.ac1};
    ac2 = {{16{cal.ac2[15]}}, cal.ac2};
    ac3 = {{16{cal.ac3[15]}}, cal.ac3};
    ac4 = {16'd0, cal.ac4};
    ac5 = {16'd0, cal.ac5};
    ac6 = {16'd0, cal.ac6};
    b1  = {{16{cal.b1[15]}}, cal.b1};
    b2  = {{16{cal.b2[15]}}, cal.b2};
    mc  = {{16{cal.mc[15]}}, cal.mc};
    md  = {{16{cal.md[15]}}, cal.md};
  end

  assign busy = 1'b0;

  // ---------------- stage 1: raw temperature product, pressure alignment
  logic        v1_r;
  logic [31:0] x1t_r, x1t_nxt;
  logic [18:0] up1_r, up1_nxt;
  logic [23:0] up_shift;

  always_comb begin
    x1t_nxt  = 32'($signed(({16'd0, in_data.raw_temperature} - ac6) * ac5) >>> 15);
    up_shift = in_data.raw_pressure >> (4'd8 - {2'd0, cal.oss});
    up1_nxt  = up_shift[18:0];
  end

  always_ff @(posedge clk) begin
    x1t_r <= x1t_nxt;
    up1_r <= up1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
  end

  // ---------------- temperature divider, signed via magnitudes
  logic [31:0]         diva, numa, diva_mag, numa_mag;
  logic                diva_zero, neg_a;
  logic [SIDE_A_W-1:0] side_a_in, side_a_out;
  logic                va_out;
  logic [31:0]         qa;

  always_comb begin
    diva      = x1t_r + md;
    numa      = mc << 11;
    diva_zero = (diva == 32'd0);
    neg_a     = numa[31] ^ diva[31];
    numa_mag  = numa[31] ? (32'd0 - numa) : numa;
    diva_mag  = diva[31] ? (32'd0 - diva) : diva;
    side_a_in = {x1t_r, up1_r, diva_zero, neg_a};
  end

  bpc_udiv_pipe #(.W(32), .SIDE_W(SIDE_A_W)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .num       (numa_mag),
    .den       (diva_mag),
    .side_in   (side_a_in),
    .out_valid (va_out),
    .quo       (qa),
    .side_out  (side_a_out)
  );

  // ---------------- stage 3: b5, temperature, b6
  logic        v3_r;
  logic [31:0] b6_r, b6_nxt;
  logic [15:0] t3_r, t3_nxt;
  logic [18:0] up3_r;
  logic        f3_r;
  logic [31:0] x2a, b5, tfull;

  always_comb begin
    x2a    = side_a_out[0] ? (32'd0 - qa) : qa;
    b5     = side_a_out[52:21] + x2a;
    tfull  = 32'($signed(b5 + 32'd8) >>> 4);
    b6_nxt = b5 - bpc_pkg::B6_OFFSET;
    if ($signed(tfull) > bpc_pkg::T_MAX)      t3_nxt = 16'h7fff;
    else if ($signed(tfull) < bpc_pkg::T_MIN) t3_nxt = 16'h8000;
    else                                      t3_nxt = tfull[15:0];
  end

  always_ff @(posedge clk) begin
    b6_r  <= b6_nxt;
    t3_r  <= t3_nxt;
    up3_r <= side_a_out[20:2];
    f3_r  <= side_a_out[1];
  end

  // ---------------- stage 4: b6 products
  logic        v4_r;
  logic [31:0] sqp4_r, p2_4_r, p3_4_r;
  logic [15:0] t4_r;
  logic [18:0] up4_r;
  logic        f4_r;

  always_ff @(posedge clk) begin
    sqp4_r <= b6_r * b6_r;
    p2_4_r <= ac2 * b6_r;
    p3_4_r <= ac3 * b6_r;
    t4_r   <= t3_r;
    up4_r  <= up3_r;
    f4_r   <= f3_r;
  end

  // ---------------- stage 5: scale the products
  logic        v5_r;
  logic [31:0] sq5_r, x2a5_r, x1c5_r;
  logic [15:0] t5_r;
  logic [18:0] up5_r;
  logic        f5_r;

  always_ff @(posedge clk) begin
    sq5_r  <= 32'($signed(sqp4_r) >>> 12);
    x2a5_r <= 32'($signed(p2_4_r) >>> 11);
    x1c5_r <= 32'($signed(p3_4_r) >>> 13);
    t5_r   <= t4_r;
    up5_r  <= up4_r;
    f5_r   <= f4_r;
  end

  // ---------------- stage 6: b1 and b2 terms
  logic        v6_r;
  logic [31:0] m1_6_r, m2_6_r, x2a6_r, x1c6_r;
  logic [15:0] t6_r;
  logic [18:0] up6_r;
  logic        f6_r;

  always_ff @(posedge clk) begin
    m1_6_r <= b2 * sq5_r;
    m2_6_r <= b1 * sq5_r;
    x2a6_r <= x2a5_r;
    x1c6_r <= x1c5_r;
    t6_r   <= t5_r;
    up6_r  <= up5_r;
    f6_r   <= f5_r;
  end

  // ---------------- stage 7: b3 and the b4 term
  logic        v7_r;
  logic [31:0] b3_7_r, x3b7_r;
  logic [15:0] t7_r;
  logic [18:0] up7_r;
  logic        f7_r;
  logic [31:0] s7_x1, s7_x3, s7_b3pre, s7_x2, s7_sum, s7_b3, s7_x3b;

  always_comb begin
    s7_x1    = 32'($signed(m1_6_r) >>> 11);
    s7_x3    = s7_x1 + x2a6_r;
    s7_b3pre = ((ac1 << 2) + s7_x3) << cal.oss;
    s7_b3    = 32'($signed(s7_b3pre + 32'd2) >>> 2);
    s7_x2    = 32'($signed(m2_6_r) >>> 16);
    s7_sum   = x1c6_r + s7_x2 + 32'd2;
    // divide by four, rounding toward zero
    s7_x3b   = 32'($signed(s7_sum + (s7_sum[31] ? 32'd3 : 32'd0)) >>> 2);
  end

  always_ff @(posedge clk) begin
    b3_7_r <= s7_b3;
    x3b7_r <= s7_x3b;
    t7_r   <= t6_r;
    up7_r  <= up6_r;
    f7_r   <= f6_r;
  end

  // ---------------- stage 8: b4 and up - b3
  logic        v8_r;
  logic [31:0] b4_8_r, dp8_r, s8_prod;
  logic [15:0] t8_r;
  logic        f8_r;

  always_comb begin
    s8_prod = ac4 * (x3b7_r + bpc_pkg::B4_BIAS);
  end

  always_ff @(posedge clk) begin
    b4_8_r <= s8_prod >> 15;
    dp8_r  <= {13'd0, up7_r} - b3_7_r;
    t8_r   <= t7_r;
    f8_r   <= f7_r;
  end

  // ---------------- stage 9: b7
  logic        v9_r;
  logic [31:0] b7_9_r, b4_9_r;
  logic [15:0] t9_r;
  logic        f9_r;

  always_ff @(posedge clk) begin
    b7_9_r <= dp8_r * (bpc_pkg::B7_SCALE >> cal.oss);
    b4_9_r <= b4_8_r;
    t9_r   <= t8_r;
    f9_r   <= f8_r | (b4_8_r == 32'd0);
  end

  // ---------------- pressure divider
  logic                big_b;
  logic [31:0]         numb;
  logic [SIDE_B_W-1:0] side_b_in, side_b_out;
  logic                vb_out;
  logic [31:0]         qb;

  always_comb begin
    big_b     = b7_9_r[31];
    numb      = big_b ? b7_9_r : (b7_9_r << 1);
    side_b_in = {t9_r, f9_r, big_b};
  end

  bpc_udiv_pipe #(.W(32), .SIDE_W(SIDE_B_W)) u_div_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v9_r),
    .num       (numb),
    .den       (b4_9_r),
    .side_in   (side_b_in),
    .out_valid (vb_out),
    .quo       (qb),
    .side_out  (side_b_out)
  );

  // ---------------- stage 11: correction products
  logic        v11_r;
  logic [31:0] p11_r, x1m11_r, x2_11_r;
  logic [15:0] t11_r;
  logic        f11_r;
  logic [31:0] s11_p, s11_pa, s11_x2n;

  always_comb begin
    s11_p   = side_b_out[0] ? (qb << 1) : qb;
    s11_pa  = 32'($signed(s11_p) >>> 8);
    s11_x2n = 32'd0 - (bpc_pkg::P_COEF_B * s11_p);
  end

  always_ff @(posedge clk) begin
    p11_r   <= s11_p;
    x1m11_r <= s11_pa * s11_pa;
    x2_11_r <= 32'($signed(s11_x2n) >>> 16);
    t11_r   <= side_b_out[17:2];
    f11_r   <= side_b_out[1];
  end

  // ---------------- stage 12: second-order term
  logic        v12_r;
  logic [31:0] p12_r, x1_12_r, x2_12_r;
  logic [15:0] t12_r;
  logic        f12_r;
  logic [31:0] s12_m;

  always_comb begin
    s12_m = x1m11_r * bpc_pkg::P_COEF_A;
  end

  always_ff @(posedge clk) begin
    p12_r   <= p11_r;
    x1_12_r <= 32'($signed(s12_m) >>> 16);
    x2_12_r <= x2_11_r;
    t12_r   <= t11_r;
    f12_r   <= f11_r;
  end

  // ---------------- stage 13: final pressure, saturation, output register
  logic          out_valid_r;
  bpc_pkg::out_t out_r, out_nxt;
  logic [31:0]   s13_p, s13_corr;

  always_comb begin
    s13_corr = 32'($signed(x1_12_r + x2_12_r + bpc_pkg::P_COEF_C) >>> 4);
    s13_p    = p12_r + s13_corr;
    out_nxt.temperature_tenths = t12_r;
    out_nxt.divide_fault       = 1'b0;
    if ($signed(s13_p) > bpc_pkg::P_MAX) out_nxt.pressure_pa = 20'hfffff;
    else if (s13_p[31])                  out_nxt.pressure_pa = 20'd0;
    else                                 out_nxt.pressure_pa = s13_p[19:0];
    // zero divisor anywhere: flag it and zero both results
    if (f12_r) begin
      out_nxt.temperature_tenths = 16'sd0;
      out_nxt.pressure_pa        = 20'd0;
      out_nxt.divide_fault       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits travel alongside the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v3_r        <= va_out;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      v11_r       <= vb_out;
      v12_r       <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/bpc_cfg.sv
// calibration and oversampling registers
module bpc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bpc_pkg::cal_t                      cal
);

  bpc_pkg::cal_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '{oss: bpc_pkg::OSS_RESET, default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_CAL_SIGNED_A: begin
          cal_r.ac1 <= cfg_data[47:32];
          cal_r.ac2 <= cfg_data[31:16];
          cal_r.ac3 <= cfg_data[15:0];
        end
        bpc_pkg::CFG_CAL_UNSIGNED_A: begin
          cal_r.ac4 <= cfg_data[47:32];
          cal_r.ac5 <= cfg_data[31:16];
          cal_r.ac6 <= cfg_data[15:0];
        end
        bpc_pkg::CFG_CAL_SIGNED_B: begin
          cal_r.b1 <= cfg_data[31:16];
          cal_r.b2 <= cfg_data[15:0];
        end
        bpc_pkg::CFG_CAL_SIGNED_M: begin
          cal_r.mc <= cfg_data[31:16];
          cal_r.md <= cfg_data[15:0];
        end
        bpc_pkg::CFG_OVERSAMPLING: begin
          cal_r.oss <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cal = cal_r;

endmodule

FILE: rtl/bpc_udiv_pipe.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module bpc_udiv_pipe #(
  parameter int W      = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [W-1:0]      rem_r  [W];
  logic [W-1:0]      quo_r  [W];
  logic [W-1:0]      den_r  [W];
  logic [SIDE_W-1:0] side_r [W];
  logic [W-1:0]      vld_r;

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_stage
      logic [W-1:0]      rem_p, quo_p, den_p;
      logic [SIDE_W-1:0] side_p;
      logic              vld_p;
      logic [W:0]        trial;
      logic [W:0]        diff;
      logic              ge;
      logic [W-1:0]      rem_nxt, quo_nxt;

      if (k == 0) begin : g_first
        assign rem_p  = '0;
        assign quo_p  = num;
        assign den_p  = den;
        assign side_p = side_in;
        assign vld_p  = in_valid;
      end else begin : g_next
        assign rem_p  = rem_r[k-1];
        assign quo_p  = quo_r[k-1];
        assign den_p  = den_r[k-1];
        assign side_p = side_r[k-1];
        assign vld_p  = vld_r[k-1];
      end

      always_comb begin
        trial   = {rem_p, quo_p[W-1]};
        diff    = trial - {1'b0, den_p};
        ge      = (trial >= {1'b0, den_p});
        rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
        quo_nxt = {quo_p[W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_p;
        side_r[k] <= side_p;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= vld_p;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[W-1];
  assign quo       = quo_r[W-1];
  assign side_out  = side_r[W-1];

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the barometric pressure compensation block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index past the end of the register list, writes to it must be dropped
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd5;
  // result strobe latency after an accepted transfer; sets the drain wait below
  localparam int PIPE_LATENCY = 75;
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  bpc_pkg::in_t                   in_data;
  logic                           out_valid;
  bpc_pkg::out_t                  out_data;
  logic                           cfg_we;
  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;

  barometric_pressure_compensation_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the calibration registers
  logic [47:0] cal_sa;
  logic [47:0] cal_ua;
  logic [31:0] cal_sb;
  logic [31:0] cal_sm;
  logic [1:0]  cal_oss;

  bpc_pkg::out_t pending_readings[$];
  int            fail_count;
  bit            no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("[barometric_pressure_compensation_top] ERROR");
    $finish;
  end

  function automatic logic [31:0] asr(logic [31:0] u, int n);
    return $unsigned($signed(u) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // truncating signed divide, done wide so the most negative case wraps cleanly
  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    longint q;
    q = longint'($signed(a)) / longint'($signed(b));
    return q[31:0];
  endfunction

  // integer compensation of one sample under the current calibration
  function automatic bpc_pkg::out_t compensate(bpc_pkg::in_t s);
    logic [31:0]   ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0]   ut, up, x1, x2, x3, dv, b5, t, b6, sq, b3, b4, b7, p;
    longint        ts, ps;
    bpc_pkg::out_t r;
    ac1 = sext(cal_sa[47:32]);
    ac2 = sext(cal_sa[31:16]);
    ac3 = sext(cal_sa[15:0]);
    ac4 = {16'd0, cal_ua[47:32]};
    ac5 = {16'd0, cal_ua[31:16]};
    ac6 = {16'd0, cal_ua[15:0]};
    b1  = sext(cal_sb[31:16]);
    b2  = sext(cal_sb[15:0]);
    mc  = sext(cal_sm[31:16]);
    md  = sext(cal_sm[15:0]);
    ut  = {16'd0, s.raw_temperature};
    up  = {8'd0, s.raw_pressure} >> (8 - cal_oss);
    r   = '0;
    x1 = asr((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    x2 = sdiv(mc << 11, dv);
    b5 = x1 + x2;
    t  = asr(b5 + 32'd8, 4);
    b6 = b5 - bpc_pkg::B6_OFFSET;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = sdiv(x1 + x2 + 32'd2, 32'd4);
    b4 = (ac4 * (x3 + bpc_pkg::B4_BIAS)) >> 15;
    if (b4 == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    b7 = (up - b3) * (bpc_pkg::B7_SCALE >> cal_oss);
    p  = b7[31] ? (b7 / b4) * 32'd2 : (b7 * 32'd2) / b4;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * bpc_pkg::P_COEF_A, 16);
    x2 = asr(32'd0 - bpc_pkg::P_COEF_B * p, 16);
    p  = p + asr(x1 + x2 + bpc_pkg::P_COEF_C, 4);
    ts = longint'($signed(t));
    if (ts > bpc_pkg::T_MAX) ts = bpc_pkg::T_MAX;
    if (ts < bpc_pkg::T_MIN) ts = bpc_pkg::T_MIN;
    ps = longint'($signed(p));
    if (ps > bpc_pkg::P_MAX) ps = bpc_pkg::P_MAX;
    if (ps < 0) ps = 0;
    r.temperature_tenths = ts[15:0];
    r.pressure_pa        = ps[19:0];
    return r;
  endfunction

  // every strobe is one result transfer, checked against the oldest prediction
  always @(posedge clk) begin
    bpc_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result t=%0d p=%0d f=%0b", out_data.temperature_tenths,
                   out_data.pressure_pa, out_data.divide_fault);
      end else begin
        want = pending_readings.pop_front();
        if (out_data !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
                     want.temperature_tenths, want.pressure_pa, want.divide_fault,
                     out_data.temperature_tenths, out_data.pressure_pa,
                     out_data.divide_fault);
        end
      end
    end
  end

  // mostly short gaps, a few long ones, none at all during burst stretches
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(bpc_pkg::in_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(compensate(s));
  endtask

  // wait until every prediction has been matched, then let the pipe empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpc_pkg::CFG_DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    repeat (gap) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      bpc_pkg::CFG_CAL_SIGNED_A:   cal_sa  = val[47:0];
      bpc_pkg::CFG_CAL_UNSIGNED_A: cal_ua  = val[47:0];
      bpc_pkg::CFG_CAL_SIGNED_B:   cal_sb  = val[31:0];
      bpc_pkg::CFG_CAL_SIGNED_M:   cal_sm  = val[31:0];
      bpc_pkg::CFG_OVERSAMPLING:   cal_oss = val[1:0];
      default: ;
    endcase
  endtask

  // full calibration load, only ever done with the pipe empty
  task automatic load_cal(logic [47:0] sa, logic [47:0] ua, logic [31:0] sb,
                          logic [31:0] sm, logic [1:0] oss);
    drain();
    write_reg(bpc_pkg::CFG_CAL_SIGNED_A, sa);
    write_reg(bpc_pkg::CFG_CAL_UNSIGNED_A, ua);
    write_reg(bpc_pkg::CFG_CAL_SIGNED_B, {16'hA5A5, sb});
    write_reg(bpc_pkg::CFG_CAL_SIGNED_M, {16'h5A5A, sm});
    write_reg(bpc_pkg::CFG_OVERSAMPLING,
              (48'({$urandom, $urandom}) & ~48'h3) | {46'd0, oss});
  endtask

  // typical sensor calibration with some spread on every coefficient
  task automatic load_typical(logic [1:0] oss);
    logic [15:0] j;
    j = 16'($urandom_range(0, 63));
    load_cal({16'd408 + j, 16'hFFB8 - j, 16'hC7D1 + j},
             {16'd32741 - j, 16'd32757 - j, 16'd23153 + j},
             {16'd6190 + j, 16'd4 + j},
             {16'hDDF9 + j, 16'd2868 + j}, oss);
  endtask

  function automatic bpc_pkg::in_t typical_sample();
    bpc_pkg::in_t s;
    s.raw_temperature = 16'($urandom_range(20000, 36000));
    s.raw_pressure    = 24'($urandom);
    return s;
  endfunction

  function automatic bpc_pkg::in_t any_sample();
    bpc_pkg::in_t s;
    s.raw_temperature = 16'($urandom);
    s.raw_pressure    = 24'($urandom);
    return s;
  endfunction

  // reset calibration has md, ac5 zero: temperature divisor is zero
  task automatic test_reset_cal();
    send_sample('0);
    send_sample({16'hFFFF, 24'hFFFFFF});
    send_sample(any_sample());
  endtask

  // field extremes under a typical calibration at each oversampling level
  task automatic test_field_extremes();
    for (int oss = 0; oss < 4; oss++) begin
      load_typical(oss[1:0]);
      send_sample({16'd0, 24'd0});
      send_sample({16'hFFFF, 24'hFFFFFF});
      send_sample({16'd27898, 24'd23843 << (8 - oss)});
    end
  endtask

  // unknown index must leave the calibration untouched
  task automatic test_unused_index();
    drain();
    write_reg(CFG_IDX_UNUSED, 48'({$urandom, $urandom}));
    send_sample(typical_sample());
  endtask

  // temperature saturation both ways, and zero pressure divisor
  task automatic test_special_cases();
    load_cal(48'h0, {16'd1000, 16'd0, 16'd0}, 32'h0, {16'h7FFF, 16'd1}, 2'd1);
    send_sample(any_sample());
    load_cal(48'h0, {16'd1000, 16'd0, 16'd0}, 32'h0, {16'h8000, 16'd1}, 2'd2);
    send_sample(any_sample());
    load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd0, 16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd0);
    send_sample(typical_sample());
    send_sample({16'hFFFF, 24'hFFFFFF});
    load_cal({48{1'b1}}, {48{1'b1}}, {32{1'b1}}, {32{1'b1}}, 2'd3);
    send_sample(any_sample());
    send_sample(typical_sample());
  endtask

  // random phases: mostly typical calibrations, some fully random ones
  task automatic test_random_phases();
    int r;
    for (int ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 3);
      if (r != 0)
        load_typical(2'($urandom));
      else
        load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
                 $urandom, 2'($urandom));
      no_idle = (ph % 3 == 2);
      for (int k = 0; k < 100; k++)
        send_sample(($urandom_range(0, 9) < 7) ? typical_sample() : any_sample());
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    no_idle    = 1'b0;
    cal_sa     = '0;
    cal_ua     = '0;
    cal_sb     = '0;
    cal_sm     = '0;
    cal_oss    = bpc_pkg::OSS_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_cal();
    test_field_extremes();
    test_unused_index();
    test_special_cases();
    test_random_phases();

    drain();
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("[barometric_pressure_compensation_top] OK");
    end else begin
      $display("[barometric_pressure_compensation_top] ERROR");
    end
    $finish;
  end

endmodule
